// ===== hw/rtl/spi_flash_command_sequencer_defines.svh =====
`ifndef SPI_FLASH_COMMAND_SEQUENCER_DEFINES_SVH
`define SPI_FLASH_COMMAND_SEQUENCER_DEFINES_SVH

// Same-cycle implication, sampled on aclk and held off during reset.
`define SFCS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk and held off during reset.
`define SFCS_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/sfcs_pkg.sv =====
`default_nettype none

package sfcs_pkg;

    localparam int PAGE_BITS  = 8;
    localparam int PAGE_BYTES = 1 << PAGE_BITS;
    localparam int MAX_READ   = 1024;

    // Result buffer: at most three results per transaction.
    localparam int MAX_RES   = 3;
    localparam int RES_SLOTS = 4;

    localparam logic [16:0] POLL_LIMIT_RESET = 17'd100000;

    // Input commands.
    localparam logic [2:0] CMD_ERASE   = 3'd0;
    localparam logic [2:0] CMD_PROGRAM = 3'd1;
    localparam logic [2:0] CMD_READ    = 3'd2;
    localparam logic [2:0] CMD_READ_ID = 3'd3;
    localparam logic [2:0] CMD_DATA    = 3'd4;
    localparam logic [2:0] CMD_RESP    = 3'd5;

    // Operations held while a sequence runs.
    localparam logic [1:0] OP_ERASE   = 2'd0;
    localparam logic [1:0] OP_PROGRAM = 2'd1;
    localparam logic [1:0] OP_READ    = 2'd2;
    localparam logic [1:0] OP_ID      = 2'd3;

    // Result kinds.
    localparam logic [1:0] KIND_XFER    = 2'd0;
    localparam logic [1:0] KIND_RELEASE = 2'd1;
    localparam logic [1:0] KIND_RD_BYTE = 2'd2;
    localparam logic [1:0] KIND_DONE    = 2'd3;

    // Flash opcodes and fixed bytes.
    localparam logic [7:0] OPC_WREN    = 8'h06;
    localparam logic [7:0] OPC_PROGRAM = 8'h02;
    localparam logic [7:0] OPC_READ    = 8'h03;
    localparam logic [7:0] OPC_ERASE   = 8'h81;
    localparam logic [7:0] OPC_RDID    = 8'h9F;
    localparam logic [7:0] OPC_RDSR    = 8'h05;
    localparam logic [7:0] DUMMY_BYTE  = 8'hFF;

    localparam logic STAT_OK  = 1'b0;
    localparam logic STAT_ERR = 1'b1;

    typedef struct packed {
        logic [2:0]  command;
        logic [23:0] address;
        logic [10:0] length;
        logic [7:0]  data_byte;
        logic        spi_failed;
    } sfcs_in_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  byte_value;
        logic        status;
        logic [23:0] device_id;
        logic        last;
    } sfcs_out_t;

    typedef struct packed {
        logic [1:0]                count;
        sfcs_out_t [MAX_RES-1:0]   item;
    } sfcs_res_t;

    function automatic sfcs_out_t mk_item(input logic [1:0] kind, input logic [7:0] value,
                                          input logic st, input logic [23:0] id);
        sfcs_out_t r;
        r.kind       = kind;
        r.byte_value = value;
        r.status     = st;
        r.device_id  = id;
        r.last       = 1'b0;
        return r;
    endfunction

    // Command byte followed by the three address bytes; erase sends a zero last.
    function automatic logic [7:0] header_byte(input logic [1:0] op, input logic [23:0] addr,
                                               input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0: begin
                b = (op == OP_ERASE) ? OPC_ERASE : ((op == OP_PROGRAM) ? OPC_PROGRAM : OPC_READ);
            end
            2'd1: begin
                b = addr[23:16];
            end
            2'd2: begin
                b = addr[15:8];
            end
            default: begin
                b = (op == OP_ERASE) ? 8'h00 : addr[7:0];
            end
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/sfcs_seq.sv =====
`default_nettype none

`include "spi_flash_command_sequencer_defines.svh"

module sfcs_seq (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              fire,
    input  wire sfcs_pkg::sfcs_in_t item,
    input  wire logic [16:0]       poll_limit,
    output sfcs_pkg::sfcs_res_t    res
);
    import sfcs_pkg::*;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_WE_CMD,
        PH_ST_CMD,
        PH_ST_DATA,
        PH_HEADER,
        PH_PROG_WAIT,
        PH_PROG_DATA,
        PH_READ_DATA,
        PH_ID_CMD,
        PH_ID_DATA,
        PH_POLL_CMD,
        PH_POLL_DATA
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [1:0]  op_reg, op_next;
    logic [23:0] addr_reg, addr_next;
    logic [10:0] left_reg, left_next;
    logic [1:0]  hidx_reg, hidx_next;
    logic [23:0] id_reg, id_next;
    logic [16:0] polls_reg, polls_next;

    sfcs_out_t [MAX_RES-1:0] r;
    logic [1:0]  n;
    logic [1:0]  hidx_inc;
    logic [10:0] left_dec;
    logic [16:0] polls_dec;
    logic [23:0] id_shift;
    logic [12:0] page_end;
    logic        prog_reject;
    logic [10:0] read_len;
    logic        failed;
    logic [7:0]  rx;

    sfcs_out_t rel_item;
    sfcs_out_t err_item;

    assign hidx_inc    = hidx_reg + 2'd1;
    assign left_dec    = left_reg - 11'd1;
    assign polls_dec   = polls_reg - 17'd1;
    assign failed      = item.spi_failed;
    assign rx          = item.data_byte;
    assign id_shift    = {id_reg[15:0], rx};
    assign page_end    = 13'(item.address[PAGE_BITS-1:0]) + 13'(item.length);
    assign prog_reject = (item.length == 11'd0) || (page_end > 13'(PAGE_BYTES));
    assign read_len    = (item.length > 11'(MAX_READ)) ? 11'(MAX_READ) : item.length;
    assign rel_item    = mk_item(KIND_RELEASE, 8'h00, STAT_OK, 24'h0);
    assign err_item    = mk_item(KIND_DONE, 8'h00, STAT_ERR, 24'h0);

    always_comb begin
        phase_next = phase_reg;
        op_next    = op_reg;
        addr_next  = addr_reg;
        left_next  = left_reg;
        hidx_next  = hidx_reg;
        id_next    = id_reg;
        polls_next = polls_reg;
        r          = '0;
        n          = 2'd0;

        if (item.command <= CMD_READ_ID) begin
            if (phase_reg == PH_IDLE) begin
                op_next   = item.command[1:0];
                addr_next = item.address;
                hidx_next = 2'd0;
                case (item.command[1:0])
                    OP_ID: begin
                        r[0] = mk_item(KIND_XFER, OPC_RDID, STAT_OK, 24'h0);
                        n = 2'd1;
                        phase_next = PH_ID_CMD;
                    end
                    OP_PROGRAM: begin
                        if (prog_reject) begin
                            r[0] = err_item;
                            n = 2'd1;
                            phase_next = PH_IDLE;
                        end else begin
                            left_next = item.length;
                            r[0] = mk_item(KIND_XFER, OPC_WREN, STAT_OK, 24'h0);
                            n = 2'd1;
                            phase_next = PH_WE_CMD;
                        end
                    end
                    OP_READ: begin
                        if (item.length == 11'd0) begin
                            r[0] = err_item;
                            n = 2'd1;
                            phase_next = PH_IDLE;
                        end else begin
                            left_next = read_len;
                            r[0] = mk_item(KIND_XFER, OPC_READ, STAT_OK, 24'h0);
                            n = 2'd1;
                            phase_next = PH_HEADER;
                        end
                    end
                    default: begin
                        r[0] = mk_item(KIND_XFER, OPC_WREN, STAT_OK, 24'h0);
                        n = 2'd1;
                        phase_next = PH_WE_CMD;
                    end
                endcase
            end
        end else if (item.command == CMD_DATA) begin
            if (phase_reg == PH_PROG_WAIT) begin
                r[0] = mk_item(KIND_XFER, rx, STAT_OK, 24'h0);
                n = 2'd1;
                phase_next = PH_PROG_DATA;
            end
        end else if (item.command == CMD_RESP) begin
            case (phase_reg)
                PH_WE_CMD: begin
                    r[0] = rel_item;
                    n = 2'd2;
                    if (failed) begin
                        r[1] = err_item;
                        phase_next = PH_IDLE;
                    end else begin
                        r[1] = mk_item(KIND_XFER, OPC_RDSR, STAT_OK, 24'h0);
                        phase_next = PH_ST_CMD;
                    end
                end
                PH_ST_CMD: begin
                    if (failed) begin
                        // A failed status command still goes on to the header.
                        r[0] = rel_item;
                        r[1] = mk_item(KIND_XFER, header_byte(op_reg, addr_reg, 2'd0),
                                       STAT_OK, 24'h0);
                        n = 2'd2;
                        hidx_next = 2'd0;
                        phase_next = PH_HEADER;
                    end else begin
                        r[0] = mk_item(KIND_XFER, DUMMY_BYTE, STAT_OK, 24'h0);
                        n = 2'd1;
                        phase_next = PH_ST_DATA;
                    end
                end
                PH_ST_DATA: begin
                    r[0] = rel_item;
                    n = 2'd2;
                    // A failed status read counts as all ones, so WEL looks set.
                    if (!failed && !rx[1]) begin
                        r[1] = err_item;
                        phase_next = PH_IDLE;
                    end else begin
                        r[1] = mk_item(KIND_XFER, header_byte(op_reg, addr_reg, 2'd0),
                                       STAT_OK, 24'h0);
                        hidx_next = 2'd0;
                        phase_next = PH_HEADER;
                    end
                end
                PH_HEADER: begin
                    if (failed) begin
                        r[0] = rel_item;
                        r[1] = err_item;
                        n = 2'd2;
                        phase_next = PH_IDLE;
                    end else begin
                        hidx_next = hidx_inc;
                        if (hidx_inc != 2'd0) begin
                            r[0] = mk_item(KIND_XFER, header_byte(op_reg, addr_reg, hidx_inc),
                                           STAT_OK, 24'h0);
                            n = 2'd1;
                        end else if (op_reg == OP_ERASE) begin
                            r[0] = rel_item;
                            r[1] = mk_item(KIND_XFER, OPC_RDSR, STAT_OK, 24'h0);
                            n = 2'd2;
                            phase_next = PH_POLL_CMD;
                        end else if (op_reg == OP_PROGRAM) begin
                            phase_next = PH_PROG_WAIT;
                        end else begin
                            r[0] = mk_item(KIND_XFER, DUMMY_BYTE, STAT_OK, 24'h0);
                            n = 2'd1;
                            phase_next = PH_READ_DATA;
                        end
                    end
                end
                PH_PROG_DATA: begin
                    if (failed) begin
                        r[0] = rel_item;
                        r[1] = err_item;
                        n = 2'd2;
                        phase_next = PH_IDLE;
                    end else begin
                        left_next = left_dec;
                        if (left_dec == 11'd0) begin
                            r[0] = rel_item;
                            r[1] = mk_item(KIND_XFER, OPC_RDSR, STAT_OK, 24'h0);
                            n = 2'd2;
                            phase_next = PH_POLL_CMD;
                        end else begin
                            phase_next = PH_PROG_WAIT;
                        end
                    end
                end
                PH_READ_DATA: begin
                    if (failed) begin
                        r[0] = rel_item;
                        r[1] = err_item;
                        n = 2'd2;
                        phase_next = PH_IDLE;
                    end else begin
                        r[0] = mk_item(KIND_RD_BYTE, rx, STAT_OK, 24'h0);
                        left_next = left_dec;
                        if (left_dec == 11'd0) begin
                            r[1] = rel_item;
                            r[2] = mk_item(KIND_DONE, 8'h00, STAT_OK, 24'h0);
                            n = 2'd3;
                            phase_next = PH_IDLE;
                        end else begin
                            r[1] = mk_item(KIND_XFER, DUMMY_BYTE, STAT_OK, 24'h0);
                            n = 2'd2;
                        end
                    end
                end
                PH_ID_CMD: begin
                    if (failed) begin
                        r[0] = rel_item;
                        r[1] = err_item;
                        n = 2'd2;
                        phase_next = PH_IDLE;
                    end else begin
                        hidx_next = 2'd0;
                        id_next = 24'h0;
                        r[0] = mk_item(KIND_XFER, DUMMY_BYTE, STAT_OK, 24'h0);
                        n = 2'd1;
                        phase_next = PH_ID_DATA;
                    end
                end
                PH_ID_DATA: begin
                    if (failed) begin
                        r[0] = rel_item;
                        r[1] = err_item;
                        n = 2'd2;
                        phase_next = PH_IDLE;
                    end else begin
                        id_next = id_shift;
                        hidx_next = hidx_inc;
                        if (hidx_inc == 2'd3) begin
                            r[0] = rel_item;
                            r[1] = mk_item(KIND_DONE, 8'h00, STAT_OK, id_shift);
                            n = 2'd2;
                            phase_next = PH_IDLE;
                        end else begin
                            r[0] = mk_item(KIND_XFER, DUMMY_BYTE, STAT_OK, 24'h0);
                            n = 2'd1;
                        end
                    end
                end
                PH_POLL_CMD: begin
                    // Poll failures still report success.
                    if (failed) begin
                        r[0] = rel_item;
                        r[1] = mk_item(KIND_DONE, 8'h00, STAT_OK, 24'h0);
                        n = 2'd2;
                        phase_next = PH_IDLE;
                    end else begin
                        polls_next = (poll_limit == 17'd0) ? 17'd1 : poll_limit;
                        r[0] = mk_item(KIND_XFER, DUMMY_BYTE, STAT_OK, 24'h0);
                        n = 2'd1;
                        phase_next = PH_POLL_DATA;
                    end
                end
                PH_POLL_DATA: begin
                    r[0] = rel_item;
                    r[1] = mk_item(KIND_DONE, 8'h00, STAT_OK, 24'h0);
                    n = 2'd2;
                    phase_next = PH_IDLE;
                    if (!failed && rx[0]) begin
                        polls_next = polls_dec;
                        if (polls_dec != 17'd0) begin
                            r[0] = mk_item(KIND_XFER, DUMMY_BYTE, STAT_OK, 24'h0);
                            r[1] = '0;
                            n = 2'd1;
                            phase_next = PH_POLL_DATA;
                        end
                    end
                end
                default: begin
                    phase_next = phase_reg;
                end
            endcase
        end

        if (n != 2'd0) begin
            r[n - 2'd1].last = 1'b1;
        end
    end

    assign res.count = n;
    assign res.item  = r;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            op_reg    <= 2'd0;
            addr_reg  <= 24'h0;
            left_reg  <= 11'd0;
            hidx_reg  <= 2'd0;
            id_reg    <= 24'h0;
            polls_reg <= 17'd0;
        end else if (fire) begin
            phase_reg <= phase_next;
            op_reg    <= op_next;
            addr_reg  <= addr_next;
            left_reg  <= left_next;
            hidx_reg  <= hidx_next;
            id_reg    <= id_next;
            polls_reg <= polls_next;
        end
    end

    `SFCS_ASSERT_IMP(a_last_marked, fire && (res.count != 2'd0), res.item[res.count - 2'd1].last, "final result of a transaction lacks last")
    `SFCS_ASSERT_NXT(a_done_idles, fire && (res.count != 2'd0) && (res.item[res.count - 2'd1].kind == KIND_DONE), phase_reg == PH_IDLE, "done result did not return the sequencer to idle")

endmodule

`default_nettype wire

// ===== hw/rtl/sfcs_res_buf.sv =====
`default_nettype none

`include "spi_flash_command_sequencer_defines.svh"

module sfcs_res_buf (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  wire sfcs_pkg::sfcs_res_t grp,
    output logic                   room,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output sfcs_pkg::sfcs_out_t    m_item
);
    import sfcs_pkg::*;

    sfcs_out_t [RES_SLOTS-1:0] slots_reg, slots_next;
    logic [2:0] count_reg, count_next;
    logic [2:0] cnt_ap;
    logic [2:0] pos;
    logic       pop;

    assign m_valid = (count_reg != 3'd0);
    assign m_item  = slots_reg[0];
    assign pop     = m_valid && m_ready;
    assign cnt_ap  = count_reg - {2'b00, pop};
    // Room for a full group of results after this cycle's pop.
    assign room    = (cnt_ap <= 3'(RES_SLOTS - MAX_RES));

    always_comb begin
        slots_next = slots_reg;
        pos = 3'd0;
        for (int i = 0; i < RES_SLOTS - 1; i++) begin
            if (pop) begin
                slots_next[i] = slots_reg[i + 1];
            end
        end
        for (int i = 0; i < RES_SLOTS; i++) begin
            pos = 3'(i) - cnt_ap;
            if (push && (3'(i) >= cnt_ap) && (pos < {1'b0, grp.count})) begin
                slots_next[i] = grp.item[pos[1:0]];
            end
        end
        count_next = cnt_ap + (push ? {1'b0, grp.count} : 3'd0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 3'd0;
        end else begin
            count_reg <= count_next;
        end
        slots_reg <= slots_next;
    end

    `SFCS_ASSERT_IMP(a_no_overflow, push, (cnt_ap + {1'b0, grp.count}) <= 3'(RES_SLOTS), "result buffer overflow")
    `SFCS_ASSERT_NXT(a_idle_drains, pop && !push, count_reg == $past(count_reg) - 3'd1, "result buffer count did not drop on a pop")

endmodule

`default_nettype wire

// ===== hw/rtl/spi_flash_command_sequencer.sv =====
// An accepted transaction is registered at the input, processed by the sequencer once the
// result buffer has room, and its results are registered in that buffer for the m_ side.
// Throughput: one transaction per cycle while each yields at most one result and m_ready
// stays high; one that yields several sends them one by one over the single result port
// through a four-entry buffer. Reset (aresetn low at a clock edge): sequencer idle,
// counters cleared, buffer empty, poll_limit_reg back to 100000.
`default_nettype none

`include "spi_flash_command_sequencer_defines.svh"

module spi_flash_command_sequencer (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_wr_en,
    input  wire logic [16:0]       cfg_wr_data,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire sfcs_pkg::sfcs_in_t s_item,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output sfcs_pkg::sfcs_out_t    m_item
);
    import sfcs_pkg::*;

    logic        in_valid_reg;
    sfcs_in_t    in_item_reg;
    logic [16:0] poll_limit_reg;
    logic        room;
    logic        fire;
    sfcs_res_t   res;

    assign fire    = in_valid_reg && room;
    assign s_ready = !in_valid_reg || fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            poll_limit_reg <= POLL_LIMIT_RESET;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (cfg_wr_en) begin
                poll_limit_reg <= cfg_wr_data;
            end
        end
        if (s_valid && s_ready) begin
            in_item_reg <= s_item;
        end
    end

    sfcs_seq u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .fire       (fire),
        .item       (in_item_reg),
        .poll_limit (poll_limit_reg),
        .res        (res)
    );

    sfcs_res_buf u_res_buf (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (fire),
        .grp     (res),
        .room    (room),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    `SFCS_ASSERT_NXT(a_held_item, in_valid_reg && !room, in_valid_reg && $stable(in_item_reg), "pending transaction lost while the result buffer was full")

endmodule

`default_nettype wire

// ===== sim/flash_seq_tracker_pkg.sv =====
package flash_seq_tracker_pkg;

    import sfcs_pkg::*;

    // Status register bits seen in a status read.
    localparam int BUSY_BIT = 0;
    localparam int WEL_BIT  = 1;

    // Command codes with no meaning to the sequencer.
    localparam logic [2:0] CMD_SPARE_6 = 3'd6;
    localparam logic [2:0] CMD_SPARE_7 = 3'd7;

    typedef enum logic [3:0] {
        SEQ_IDLE,
        SEQ_WREN,
        SEQ_STAT_CMD,
        SEQ_STAT_DATA,
        SEQ_HEADER,
        SEQ_PROG_WAIT,
        SEQ_PROG_DATA,
        SEQ_READ_DATA,
        SEQ_ID_CMD,
        SEQ_ID_DATA,
        SEQ_POLL_CMD,
        SEQ_POLL_DATA
    } seq_phase_t;

    class flash_seq_tracker;
        seq_phase_t  phase;
        logic [1:0]  op;
        logic [23:0] addr;
        logic [10:0] remaining;
        logic [1:0]  hdr;
        logic [23:0] id_acc;
        logic [16:0] polls;
        logic [16:0] poll_limit;
        sfcs_out_t   due_results[$];
        sfcs_out_t   batch[$];
        int          errors;

        function new();
            phase      = SEQ_IDLE;
            op         = OP_ERASE;
            addr       = '0;
            remaining  = '0;
            hdr        = '0;
            id_acc     = '0;
            polls      = '0;
            poll_limit = POLL_LIMIT_RESET;
            errors     = 0;
        endfunction

        function void set_poll_limit(logic [16:0] v);
            poll_limit = v;
        endfunction

        function void emit(logic [1:0] kind, logic [7:0] value, logic st, logic [23:0] id);
            sfcs_out_t r;
            r.kind       = kind;
            r.byte_value = value;
            r.status     = st;
            r.device_id  = id;
            r.last       = 1'b0;
            batch.push_back(r);
        endfunction

        function void finish_op(logic st, logic [23:0] id);
            emit(KIND_DONE, 8'h00, st, id);
            phase = SEQ_IDLE;
        endfunction

        function void abort_op();
            emit(KIND_RELEASE, 8'h00, STAT_OK, 24'h0);
            finish_op(STAT_ERR, 24'h0);
        endfunction

        function void wrap_up(logic [23:0] id);
            emit(KIND_RELEASE, 8'h00, STAT_OK, 24'h0);
            finish_op(STAT_OK, id);
        endfunction

        // Opcode, then the address high to low; erase ends with a zero byte.
        function logic [7:0] header_at(logic [1:0] idx);
            case (idx)
                2'd0: begin
                    case (op)
                        OP_ERASE:   return OPC_ERASE;
                        OP_PROGRAM: return OPC_PROGRAM;
                        default:    return OPC_READ;
                    endcase
                end
                2'd1: return addr[23:16];
                2'd2: return addr[15:8];
                default: return (op == OP_ERASE) ? 8'h00 : addr[7:0];
            endcase
        endfunction

        function void start_header();
            hdr = 2'd0;
            emit(KIND_XFER, header_at(2'd0), STAT_OK, 24'h0);
            phase = SEQ_HEADER;
        endfunction

        function void start_poll();
            emit(KIND_RELEASE, 8'h00, STAT_OK, 24'h0);
            emit(KIND_XFER, OPC_RDSR, STAT_OK, 24'h0);
            phase = SEQ_POLL_CMD;
        endfunction

        function void begin_operation(logic [1:0] kind_of_op, logic [23:0] a, logic [10:0] len);
            int offs;
            op   = kind_of_op;
            addr = a;
            hdr  = 2'd0;
            offs = int'(a) % PAGE_BYTES;
            case (kind_of_op)
                OP_ID: begin
                    emit(KIND_XFER, OPC_RDID, STAT_OK, 24'h0);
                    phase = SEQ_ID_CMD;
                end
                OP_PROGRAM: begin
                    if (len == 0 || offs + int'(len) > PAGE_BYTES) begin
                        finish_op(STAT_ERR, 24'h0);
                    end else begin
                        remaining = len;
                        emit(KIND_XFER, OPC_WREN, STAT_OK, 24'h0);
                        phase = SEQ_WREN;
                    end
                end
                OP_READ: begin
                    if (len == 0) begin
                        finish_op(STAT_ERR, 24'h0);
                    end else begin
                        remaining = (int'(len) > MAX_READ) ? 11'(MAX_READ) : len;
                        start_header();
                    end
                end
                default: begin
                    emit(KIND_XFER, OPC_WREN, STAT_OK, 24'h0);
                    phase = SEQ_WREN;
                end
            endcase
        endfunction

        function void advance(logic [7:0] rx, logic failed);
            logic [7:0] st;
            case (phase)
                SEQ_WREN: begin
                    emit(KIND_RELEASE, 8'h00, STAT_OK, 24'h0);
                    if (failed) begin
                        finish_op(STAT_ERR, 24'h0);
                    end else begin
                        emit(KIND_XFER, OPC_RDSR, STAT_OK, 24'h0);
                        phase = SEQ_STAT_CMD;
                    end
                end
                SEQ_STAT_CMD: begin
                    // A failed status command skips the WEL check entirely.
                    if (failed) begin
                        emit(KIND_RELEASE, 8'h00, STAT_OK, 24'h0);
                        start_header();
                    end else begin
                        emit(KIND_XFER, DUMMY_BYTE, STAT_OK, 24'h0);
                        phase = SEQ_STAT_DATA;
                    end
                end
                SEQ_STAT_DATA: begin
                    emit(KIND_RELEASE, 8'h00, STAT_OK, 24'h0);
                    st = failed ? 8'hFF : rx;
                    if (!st[WEL_BIT]) begin
                        finish_op(STAT_ERR, 24'h0);
                    end else begin
                        start_header();
                    end
                end
                SEQ_HEADER: begin
                    if (failed) begin
                        abort_op();
                    end else begin
                        hdr = hdr + 2'd1;
                        if (hdr != 2'd0) begin
                            emit(KIND_XFER, header_at(hdr), STAT_OK, 24'h0);
                        end else if (op == OP_ERASE) begin
                            start_poll();
                        end else if (op == OP_PROGRAM) begin
                            phase = SEQ_PROG_WAIT;
                        end else begin
                            emit(KIND_XFER, DUMMY_BYTE, STAT_OK, 24'h0);
                            phase = SEQ_READ_DATA;
                        end
                    end
                end
                SEQ_PROG_DATA: begin
                    if (failed) begin
                        abort_op();
                    end else begin
                        remaining = remaining - 11'd1;
                        if (remaining == 0) begin
                            start_poll();
                        end else begin
                            phase = SEQ_PROG_WAIT;
                        end
                    end
                end
                SEQ_READ_DATA: begin
                    if (failed) begin
                        abort_op();
                    end else begin
                        emit(KIND_RD_BYTE, rx, STAT_OK, 24'h0);
                        remaining = remaining - 11'd1;
                        if (remaining == 0) begin
                            wrap_up(24'h0);
                        end else begin
                            emit(KIND_XFER, DUMMY_BYTE, STAT_OK, 24'h0);
                        end
                    end
                end
                SEQ_ID_CMD: begin
                    if (failed) begin
                        abort_op();
                    end else begin
                        hdr    = 2'd0;
                        id_acc = 24'h0;
                        emit(KIND_XFER, DUMMY_BYTE, STAT_OK, 24'h0);
                        phase = SEQ_ID_DATA;
                    end
                end
                SEQ_ID_DATA: begin
                    if (failed) begin
                        abort_op();
                    end else begin
                        id_acc = {id_acc[15:0], rx};
                        hdr    = hdr + 2'd1;
                        if (hdr == 2'd3) begin
                            wrap_up(id_acc);
                        end else begin
                            emit(KIND_XFER, DUMMY_BYTE, STAT_OK, 24'h0);
                        end
                    end
                end
                SEQ_POLL_CMD: begin
                    // Polling problems never turn into an error.
                    if (failed) begin
                        wrap_up(24'h0);
                    end else begin
                        polls = (poll_limit == 0) ? 17'd1 : poll_limit;
                        emit(KIND_XFER, DUMMY_BYTE, STAT_OK, 24'h0);
                        phase = SEQ_POLL_DATA;
                    end
                end
                SEQ_POLL_DATA: begin
                    if (failed) begin
                        wrap_up(24'h0);
                    end else if (rx[BUSY_BIT] && polls != 17'd1) begin
                        polls = polls - 17'd1;
                        emit(KIND_XFER, DUMMY_BYTE, STAT_OK, 24'h0);
                    end else begin
                        wrap_up(24'h0);
                    end
                end
                default: begin
                end
            endcase
        endfunction

        // Predicts the results of one accepted transaction; returns 1 unless it was ignored.
        function bit accept_item(sfcs_in_t it);
            seq_phase_t was;
            was = phase;
            batch.delete();
            case (it.command)
                CMD_ERASE, CMD_PROGRAM, CMD_READ, CMD_READ_ID: begin
                    if (phase == SEQ_IDLE) begin
                        begin_operation(it.command[1:0], it.address, it.length);
                    end
                end
                CMD_DATA: begin
                    if (phase == SEQ_PROG_WAIT) begin
                        emit(KIND_XFER, it.data_byte, STAT_OK, 24'h0);
                        phase = SEQ_PROG_DATA;
                    end
                end
                CMD_RESP: begin
                    advance(it.data_byte, it.spi_failed);
                end
                default: begin
                end
            endcase
            if (batch.size() > 0) begin
                batch[batch.size() - 1].last = 1'b1;
            end
            foreach (batch[k]) begin
                due_results.push_back(batch[k]);
            end
            return (batch.size() > 0) || (phase != was);
        endfunction

        function void report(string field, longint unsigned want, longint unsigned got);
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
            errors++;
        endfunction

        function void check_result(sfcs_out_t got);
            sfcs_out_t want;
            if (due_results.size() == 0) begin
                $display("%0t: result with none expected, expected nothing, actual %p",
                         $time, got);
                errors++;
            end else begin
                want = due_results.pop_front();
                if (got.kind !== want.kind) report("kind", want.kind, got.kind);
                if (got.byte_value !== want.byte_value) begin
                    report("byte_value", want.byte_value, got.byte_value);
                end
                if (got.status !== want.status) report("status", want.status, got.status);
                if (got.device_id !== want.device_id) begin
                    report("device_id", want.device_id, got.device_id);
                end
                if (got.last !== want.last) report("last", want.last, got.last);
            end
        endfunction
    endclass

endpackage

// ===== sim/tb_top.sv =====
module tb_top;

    import sfcs_pkg::*;
    import flash_seq_tracker_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int          HOLD_CYCLES = 400;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [16:0] cfg_wr_data = '0;
    logic        s_valid     = 1'b0;
    logic        s_ready;
    sfcs_in_t    s_item      = '0;
    logic        m_valid;
    logic        m_ready     = 1'b0;
    sfcs_out_t   m_item;

    flash_seq_tracker tracker = new();

    bit          calm          = 1'b0;
    bit          pressure_on   = 1'b0;
    bit          pressure_done = 1'b0;
    bit          last_taken    = 1'b0;
    int unsigned cycles        = 0;

    always #5 aclk = ~aclk;

    spi_flash_command_sequencer dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_item      (s_item),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_item      (m_item)
    );

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            tracker.check_result(m_item);
        end
    end

    // Result side: random stalls, none while calm, and one long hold-off on request.
    initial begin
        forever begin
            @(posedge aclk);
            if (pressure_on && !pressure_done) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                pressure_done = 1'b1;
            end else if (calm) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= 30);
            end
        end
    end

    function automatic sfcs_in_t mk(logic [2:0] c, logic [23:0] a, logic [10:0] n,
                                    logic [7:0] d, logic f);
        sfcs_in_t it;
        it.command    = c;
        it.address    = a;
        it.length     = n;
        it.data_byte  = d;
        it.spi_failed = f;
        return it;
    endfunction

    // Mostly what the sequencer is waiting for, with random content; the rest is noise.
    function automatic sfcs_in_t next_item(int noise_pct, int fail_pct);
        sfcs_in_t it;
        int       offs;
        int       room;
        int       r;
        it.command    = CMD_RESP;
        it.address    = 24'($urandom);
        it.length     = 11'($urandom);
        it.data_byte  = 8'($urandom);
        it.spi_failed = 1'($urandom);
        if ($urandom_range(0, 99) < noise_pct) begin
            it.command = 3'($urandom_range(0, 7));
            // Keep stray reads short so that noise cannot start a huge transfer.
            if (tracker.phase == SEQ_IDLE && it.command == CMD_READ) begin
                it.length = {7'd0, it.length[3:0]};
            end
            return it;
        end
        it.spi_failed = ($urandom_range(0, 99) < fail_pct);
        r = $urandom_range(0, 99);
        case (tracker.phase)
            SEQ_IDLE: begin
                case ($urandom_range(0, 3))
                    0: it.command = CMD_ERASE;
                    1: it.command = CMD_PROGRAM;
                    2: it.command = CMD_READ;
                    default: it.command = CMD_READ_ID;
                endcase
                if (it.command == CMD_PROGRAM) begin
                    offs = int'(it.address) % PAGE_BYTES;
                    room = PAGE_BYTES - offs;
                    if (r < 10) begin
                        it.length = '0;
                    end else if (r < 20) begin
                        it.length = 11'(room + $urandom_range(1, 8));
                    end else begin
                        it.length = 11'($urandom_range(1, (room < 8) ? room : 8));
                    end
                end else if (it.command == CMD_READ) begin
                    if (r < 5) begin
                        it.length = '0;
                    end else if (r < 15) begin
                        it.length = 11'($urandom_range(9, 40));
                    end else begin
                        it.length = 11'($urandom_range(1, 8));
                    end
                end
            end
            SEQ_PROG_WAIT: begin
                it.command = CMD_DATA;
            end
            SEQ_STAT_DATA: begin
                it.data_byte[WEL_BIT] = (r < 85);
            end
            SEQ_POLL_DATA: begin
                it.data_byte[BUSY_BIT] = (r < 60);
            end
            default: begin
            end
        endcase
        return it;
    endfunction

    task automatic push_item(input sfcs_in_t it);
        s_valid <= 1'b1;
        s_item  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        last_taken = tracker.accept_item(it);
        if (!calm && $urandom_range(0, 99) < 30) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
    endtask

    task automatic run_random(input int unsigned goal);
        int unsigned taken_n;
        taken_n = 0;
        while (taken_n < goal) begin
            push_item(next_item(20, 4));
            if (last_taken) taken_n++;
        end
    endtask

    // Bring the sequencer back to idle and let every expected result drain out.
    task automatic settle_idle();
        while (tracker.phase != SEQ_IDLE) push_item(next_item(0, 4));
        s_valid <= 1'b0;
        while (tracker.due_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_poll_limit(input logic [16:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        tracker.set_poll_limit(v);
    endtask

    task automatic run_directed();
        push_item(mk(CMD_RESP, 24'h000000, 11'd0, 8'h00, 1'b0));
        push_item(mk(CMD_SPARE_6, 24'hFFFFFF, 11'h7FF, 8'hFF, 1'b1));
        push_item(mk(CMD_SPARE_7, 24'h000000, 11'd0, 8'h00, 1'b0));
        push_item(mk(CMD_DATA, 24'h000000, 11'd0, 8'hFF, 1'b0));
        push_item(mk(CMD_PROGRAM, 24'h000000, 11'd0, 8'h00, 1'b0));
        push_item(mk(CMD_PROGRAM, 24'h0000FF, 11'd2, 8'h00, 1'b0));
        push_item(mk(CMD_READ, 24'hFFFFFF, 11'd0, 8'h00, 1'b0));
        // An ID read, with an erase offered while it is still running.
        push_item(mk(CMD_READ_ID, 24'h000000, 11'd0, 8'h00, 1'b0));
        push_item(mk(CMD_ERASE, 24'h123456, 11'd1, 8'h00, 1'b0));
        push_item(mk(CMD_RESP, 24'h000000, 11'd0, 8'h00, 1'b0));
        push_item(mk(CMD_RESP, 24'h000000, 11'd0, 8'hFF, 1'b0));
        push_item(mk(CMD_RESP, 24'h000000, 11'd0, 8'h00, 1'b0));
        push_item(mk(CMD_RESP, 24'h000000, 11'd0, 8'hA5, 1'b0));
        // Erase at the top address; the status command fails, which skips the WEL check.
        push_item(mk(CMD_ERASE, 24'hFFFFFF, 11'h7FF, 8'h00, 1'b0));
        push_item(mk(CMD_RESP, 24'h000000, 11'd0, 8'h00, 1'b0));
        push_item(mk(CMD_RESP, 24'h000000, 11'd0, 8'h00, 1'b1));
        push_item(mk(CMD_RESP, 24'h000000, 11'd0, 8'h00, 1'b0));
        push_item(mk(CMD_RESP, 24'h000000, 11'd0, 8'h00, 1'b0));
        push_item(mk(CMD_RESP, 24'h000000, 11'd0, 8'h00, 1'b0));
        push_item(mk(CMD_RESP, 24'h000000, 11'd0, 8'h00, 1'b0));
        push_item(mk(CMD_RESP, 24'h000000, 11'd0, 8'h00, 1'b0));
        push_item(mk(CMD_RESP, 24'h000000, 11'd0, 8'h01, 1'b0));
        push_item(mk(CMD_RESP, 24'h000000, 11'd0, 8'hFE, 1'b0));
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        run_directed();
        settle_idle();

        write_poll_limit(17'd1);
        run_random(120);
        settle_idle();

        // Largest poll limit with both sides running flat out.
        write_poll_limit(17'h1FFFF);
        calm = 1'b1;
        run_random(110);
        settle_idle();
        calm = 1'b0;

        // Zero behaves as a limit of one; the result side also stops for a long while.
        write_poll_limit(17'd0);
        pressure_on = 1'b1;
        run_random(110);
        settle_idle();

        if (tracker.errors == 0 && tracker.due_results.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
